// ===== rtl/core/tape_header_parser_unit_defines.svh =====
// assertion macros shared by the tape header parser rtl
`ifndef TAPE_HEADER_PARSER_UNIT_DEFINES_SVH
`define TAPE_HEADER_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define THP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define THP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/thp_pkg.sv =====
// shared types and constants of the tape header parser
package thp_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h16;
   localparam logic [7:0] MARK_BYTE  = 8'h24;
   localparam logic [7:0] BASIC_BYTE = 8'h80;
   localparam logic [7:0] AUTO_BYTE  = 8'hC7;

   localparam logic [1:0] KIND_NAME = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;

   typedef enum logic [10:0] {
      PH_SYNC     = 11'b000_0000_0001,
      PH_DROP1    = 11'b000_0000_0010,
      PH_DROP2    = 11'b000_0000_0100,
      PH_TYPE     = 11'b000_0000_1000,
      PH_AUTO     = 11'b000_0001_0000,
      PH_END_HI   = 11'b000_0010_0000,
      PH_END_LO   = 11'b000_0100_0000,
      PH_START_HI = 11'b000_1000_0000,
      PH_START_LO = 11'b001_0000_0000,
      PH_DROP3    = 11'b010_0000_0000,
      PH_NAME     = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  name_byte;
      logic        is_basic;
      logic        autostart;
      logic [15:0] start_address;
      logic [15:0] end_address;
   } rsp_data_type;

   typedef struct packed {
      logic         emit;
      rsp_data_type data;
   } parse_result_type;

endpackage

// ===== rtl/core/thp_channels.sv =====
// valid/ready channel interfaces for header bytes and parse results
interface thp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface thp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  name_byte;
   logic        is_basic;
   logic        autostart;
   logic [15:0] start_address;
   logic [15:0] end_address;

   modport source (output valid, output kind, output name_byte, output is_basic,
                   output autostart, output start_address, output end_address,
                   input ready);
   modport sink (input valid, input kind, input name_byte, input is_basic,
                 input autostart, input start_address, input end_address,
                 output ready);
endinterface

// ===== rtl/core/tape_header_parser_unit.sv =====
// tape header parser top level: input register, phase machine, result register
//
//   channel | dir | transfer when          | payload
//   req     | in  | req.valid & req.ready  | data_byte
//   rsp     | out | rsp.valid & rsp.ready  | kind, name_byte, is_basic, autostart,
//           |     |                        | start_address, end_address
//
// one byte per cycle while rsp does not stall; a byte waits in the input register and
// its result, if any, shows on rsp the cycle after it is parsed
// the phase machine steps once per byte, so byte order sets all latency
// synchronous active-high reset returns to sync hunting and clears flags and addresses
// a stalled rsp only holds bytes that would produce a result; others drain freely
module tape_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   thp_req_if.sink     req,
   thp_rsp_if.source   rsp
);
   import thp_pkg::*;
   `include "tape_header_parser_unit_defines.svh"

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic             req_xfer;
   logic             advance;
   logic             out_free;
   parse_result_type res;
   rsp_data_type     rsp_data;

   // a byte leaves the input register when it makes no result or the result slot frees
   assign advance     = in_valid_ff && (!res.emit || out_free);
   assign req.ready   = !in_valid_ff || advance;
   assign req_xfer    = req.valid && req.ready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req.data_byte;
      end
   end

   // phase machine, stepped once per parsed byte
   thp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .res       (res)
   );

   // result register
   thp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res.emit),
      .load_data (res.data),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp.kind          = rsp_data.kind;
   assign rsp.name_byte     = rsp_data.name_byte;
   assign rsp.is_basic      = rsp_data.is_basic;
   assign rsp.autostart     = rsp_data.autostart;
   assign rsp.start_address = rsp_data.start_address;
   assign rsp.end_address   = rsp_data.end_address;

   // a held byte stays put until it is parsed
   `THP_ASSERT_NEXT(a_hold_byte, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff), "held input byte lost or changed")

   // name results never carry the terminating zero
   `THP_ASSERT_IMPLY(a_name_nonzero, clock, reset, rsp.valid && (rsp.kind == KIND_NAME), rsp.name_byte != 8'h00, "zero name byte sent")

   // only defined result kinds leave the block
   `THP_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp.valid, (rsp.kind == KIND_NAME) || (rsp.kind == KIND_DONE) || (rsp.kind == KIND_BAD), "undefined result kind")

endmodule

// ===== rtl/core/thp_parse.sv =====
// header phase machine, flag and address capture, result decode
module thp_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   output thp_pkg::parse_result_type res
);
   import thp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        basic_ff, basic_in;
   logic        auto_ff, auto_in;
   logic [15:0] end_addr_ff, end_addr_in;
   logic [15:0] start_addr_ff, start_addr_in;

   always_comb begin
      phase_in      = phase_ff;
      basic_in      = basic_ff;
      auto_in       = auto_ff;
      end_addr_in   = end_addr_ff;
      start_addr_in = start_addr_ff;
      res           = '0;
      unique case (phase_ff)
         PH_DROP1:    phase_in = PH_DROP2;
         PH_DROP2:    phase_in = PH_TYPE;
         PH_TYPE: begin
            basic_in = (data_byte == BASIC_BYTE);
            phase_in = PH_AUTO;
         end
         PH_AUTO: begin
            auto_in  = (data_byte == AUTO_BYTE);
            phase_in = PH_END_HI;
         end
         PH_END_HI: begin
            end_addr_in[15:8] = data_byte;
            phase_in          = PH_END_LO;
         end
         PH_END_LO: begin
            end_addr_in[7:0] = data_byte;
            phase_in         = PH_START_HI;
         end
         PH_START_HI: begin
            start_addr_in[15:8] = data_byte;
            phase_in            = PH_START_LO;
         end
         PH_START_LO: begin
            start_addr_in[7:0] = data_byte;
            phase_in           = PH_DROP3;
         end
         PH_DROP3:    phase_in = PH_NAME;
         PH_NAME: begin
            res.emit = 1'b1;
            if (data_byte != 8'h00) begin
               res.data.kind      = KIND_NAME;
               res.data.name_byte = data_byte;
            end else begin
               res.data.kind          = KIND_DONE;
               res.data.is_basic      = basic_ff;
               res.data.autostart     = auto_ff;
               res.data.start_address = start_addr_ff;
               res.data.end_address   = end_addr_ff;
               phase_in               = PH_SYNC;
            end
         end
         default: begin
            // sync hunting
            phase_in = PH_SYNC;
            if (data_byte == MARK_BYTE) begin
               phase_in = PH_DROP1;
            end else if (data_byte != SYNC_BYTE) begin
               res.emit      = 1'b1;
               res.data.kind = KIND_BAD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC;
         basic_ff      <= 1'b0;
         auto_ff       <= 1'b0;
         end_addr_ff   <= '0;
         start_addr_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         basic_ff      <= basic_in;
         auto_ff       <= auto_in;
         end_addr_ff   <= end_addr_in;
         start_addr_ff <= start_addr_in;
      end
   end

endmodule

// ===== rtl/core/thp_rsp_reg.sv =====
// result output register, refilled in the cycle it drains
module thp_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  thp_pkg::rsp_data_type load_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output thp_pkg::rsp_data_type rsp_data,
   output logic                  free
);
   import thp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_data_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
